### rtl/kpst_pkg.sv
// Shared types, codes and default sizes for the key press state tracker.
`timescale 1ns / 1ps

package kpst_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned KEY_SLOTS_DEF  = 1024;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed port widths.
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned PRESS_W  = 16;

  // Request operation codes.
  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Index bank codes taken from key index bits 9:8.
  localparam logic [1:0] BANK_KEYBOARD = 2'd0;
  localparam logic [1:0] BANK_JOYPAD   = 2'd1;

  // Device codes on the leading device output.
  localparam logic [1:0] DEV_KEYBOARD = 2'd0;
  localparam logic [1:0] DEV_JOYPAD   = 2'd1;
  localparam logic [1:0] DEV_MIDI     = 2'd2;

  // Per-slot state.
  typedef enum logic [1:0] {
    SLOT_IDLE     = 2'd0,
    SLOT_NEW      = 2'd1,
    SLOT_HELD     = 2'd2,
    SLOT_RELEASED = 2'd3
  } slot_state_e;

  // Control from the slot stage to the press counters.
  typedef struct packed {
    logic       clear;
    logic       incr;
    logic [1:0] bank;
  } cnt_ctrl_t;

endpackage

### rtl/key_press_state_tracker_core.sv
// A request that is accepted passes the update stage (b_valid_q) and the result stage
// (c_valid_q) and is strobed on done_o. Throughput: one request per cycle while busy is low;
// slot state and press stamp share one RAM, read in the accept cycle and written back the
// next, with the previous write forwarded. Reset: the RAM is swept to idle with busy high;
// counters and the release window reset to zero. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module key_press_state_tracker_core #(
  parameter int unsigned KEY_SLOTS  = kpst_pkg::KEY_SLOTS_DEF,
  parameter int unsigned TIME_BITS  = kpst_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = kpst_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kpst_pkg::WINDOW_W-1:0]   cfg_wdata_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation_i,
  input  logic [kpst_pkg::INDEX_W-1:0]    key_index_i,
  input  logic                            key_pressed_i,
  input  logic [kpst_pkg::NOW_W-1:0]      now_time_i,
  output logic                            done_o,
  output logic [1:0]                      key_state_o,
  output logic [kpst_pkg::PRESS_W-1:0]    keyboard_presses_o,
  output logic [kpst_pkg::PRESS_W-1:0]    joypad_presses_o,
  output logic [kpst_pkg::PRESS_W-1:0]    midi_presses_o,
  output logic [1:0]                      leading_device_o
);
  import kpst_pkg::*;

  localparam int unsigned ADDR_W = $clog2(KEY_SLOTS);
  localparam int unsigned WORD_W = TIME_BITS + 2;

  // Configuration register.
  logic [WINDOW_W-1:0] window_q;

  // Clearing pass after reset.
  logic              clr_active_q, clr_active_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Update stage.
  logic                 b_valid_q;
  logic                 b_op_q;
  logic                 b_in_range_q;
  logic [ADDR_W-1:0]    b_addr_q;
  logic                 b_down_q;
  logic [1:0]           b_bank_q;
  logic [TIME_BITS-1:0] b_now_q;

  // Forwarding of the previous write.
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [WORD_W-1:0] fwd_word_q;

  // Result stage.
  logic        c_valid_q;
  slot_state_e c_state_q, c_state_d;

  logic                  accept;
  logic                  in_range;
  logic [WORD_W-1:0]     ram_rdata;
  logic [WORD_W-1:0]     cur_word;
  slot_state_e           cur_state;
  slot_state_e           nxt_state;
  logic                  new_press;
  logic                  scan_we;
  logic [TIME_BITS-1:0]  new_stamp;
  logic [WORD_W-1:0]     wr_word;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  cnt_ctrl_t             cnt_ctrl;
  logic [COUNT_BITS-1:0] kb_cnt;
  logic [COUNT_BITS-1:0] jp_cnt;
  logic [COUNT_BITS-1:0] midi_cnt;
  logic [1:0]            leader;

  assign busy     = clr_active_q;
  assign accept   = start && !busy;
  assign in_range = (32'(key_index_i) < 32'(KEY_SLOTS));

  // Release window register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // Clearing pass sweeps every slot to idle.
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(KEY_SLOTS - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      b_valid_q    <= 1'b0;
      fwd_valid_q  <= 1'b0;
      c_valid_q    <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      b_valid_q    <= accept;
      fwd_valid_q  <= scan_we;
      c_valid_q    <= b_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_op_q       <= operation_i;
      b_in_range_q <= in_range;
      b_addr_q     <= ADDR_W'(key_index_i);
      b_down_q     <= key_pressed_i;
      b_bank_q     <= key_index_i[INDEX_W-1 -: 2];
      b_now_q      <= TIME_BITS'(now_time_i);
    end
    if (scan_we) begin
      fwd_addr_q <= b_addr_q;
      fwd_word_q <= wr_word;
    end
    c_state_q <= c_state_d;
  end

  // Slot memory: stamp in the upper bits, state in the low two.
  kpst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (KEY_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ADDR_W'(key_index_i)),
    .rdata_o (ram_rdata)
  );

  // Take the previous write when it hit the same slot.
  assign cur_word  = (fwd_valid_q && fwd_addr_q == b_addr_q) ? fwd_word_q : ram_rdata;
  assign cur_state = slot_state_e'(cur_word[1:0]);

  kpst_slot_update #(
    .TIME_BITS (TIME_BITS)
  ) u_slot_update (
    .cur_state_i (cur_state),
    .cur_stamp_i (cur_word[WORD_W-1:2]),
    .now_i       (b_now_q),
    .window_i    (window_q),
    .down_i      (b_down_q),
    .nxt_state_o (nxt_state),
    .new_press_o (new_press)
  );

  // Write back the updated slot.
  assign scan_we   = b_valid_q && (b_op_q == OP_SCAN) && b_in_range_q;
  assign new_stamp = new_press ? b_now_q : cur_word[WORD_W-1:2];
  assign wr_word   = {new_stamp, nxt_state};
  assign ram_we    = clr_active_q || scan_we;
  assign ram_waddr = clr_active_q ? clr_cnt_q : b_addr_q;
  assign ram_wdata = clr_active_q ? '0 : wr_word;

  // Counter control.
  assign cnt_ctrl.clear = b_valid_q && (b_op_q == OP_CLEAR);
  assign cnt_ctrl.incr  = scan_we && new_press;
  assign cnt_ctrl.bank  = b_bank_q;

  kpst_counters #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cnt_ctrl),
    .keyboard_o (kb_cnt),
    .joypad_o   (jp_cnt),
    .midi_o     (midi_cnt),
    .leader_o   (leader)
  );

  // Result: counters already hold the post-update values in the result cycle.
  assign c_state_d          = scan_we ? nxt_state : SLOT_IDLE;
  assign done_o             = c_valid_q;
  assign key_state_o        = c_state_q;
  assign keyboard_presses_o = PRESS_W'(kb_cnt);
  assign joypad_presses_o   = PRESS_W'(jp_cnt);
  assign midi_presses_o     = PRESS_W'(midi_cnt);
  assign leading_device_o   = leader;

  // Every result comes from a request that was accepted while busy was low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // No request is in flight during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !b_valid_q && !scan_we)
    else $error("request in flight while clearing");

  // A clear request reports idle and zeroed counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(b_op_q == OP_CLEAR) |->
      key_state_o == SLOT_IDLE && keyboard_presses_o == '0 &&
      joypad_presses_o == '0 && midi_presses_o == '0)
    else $error("clear result not zeroed");

  // A new press always changes exactly one counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ctrl.incr && !cnt_ctrl.clear |=>
      (kb_cnt != $past(kb_cnt)) + (jp_cnt != $past(jp_cnt)) +
      (midi_cnt != $past(midi_cnt)) == 1)
    else $error("new press did not count once");

endmodule

### rtl/kpst_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module kpst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/kpst_slot_update.sv
// Next-state logic for one key slot, including the release window check.
`timescale 1ns / 1ps

module kpst_slot_update #(
  parameter int unsigned TIME_BITS = kpst_pkg::TIME_BITS_DEF
) (
  input  kpst_pkg::slot_state_e             cur_state_i,
  input  logic [TIME_BITS-1:0]              cur_stamp_i,
  input  logic [TIME_BITS-1:0]              now_i,
  input  logic [kpst_pkg::WINDOW_W-1:0]     window_i,
  input  logic                              down_i,
  output kpst_pkg::slot_state_e             nxt_state_o,
  output logic                              new_press_o
);
  import kpst_pkg::*;

  logic [TIME_BITS-1:0] since;
  logic                 in_window;

  // Wrapped time since the last new press.
  assign since     = now_i - cur_stamp_i;
  assign in_window = (since <= TIME_BITS'(window_i));

  // Slot transitions.
  always_comb begin
    nxt_state_o = SLOT_IDLE;
    new_press_o = 1'b0;
    unique case (cur_state_i)
      SLOT_IDLE: begin
        if (down_i) begin
          nxt_state_o = SLOT_NEW;
          new_press_o = 1'b1;
        end
      end
      SLOT_NEW, SLOT_HELD: begin
        if (down_i) begin
          nxt_state_o = SLOT_HELD;
        end else begin
          nxt_state_o = in_window ? SLOT_HELD : SLOT_RELEASED;
        end
      end
      SLOT_RELEASED: begin
        nxt_state_o = down_i ? SLOT_HELD : SLOT_IDLE;
      end
      default: begin
        nxt_state_o = SLOT_IDLE;
      end
    endcase
  end

endmodule

### rtl/kpst_counters.sv
// Per-device press counters and the leading device selection.
`timescale 1ns / 1ps

module kpst_counters #(
  parameter int unsigned COUNT_BITS = kpst_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kpst_pkg::cnt_ctrl_t   ctrl_i,
  output logic [COUNT_BITS-1:0] keyboard_o,
  output logic [COUNT_BITS-1:0] joypad_o,
  output logic [COUNT_BITS-1:0] midi_o,
  output logic [1:0]            leader_o
);
  import kpst_pkg::*;

  logic [COUNT_BITS-1:0] kb_q, kb_d;
  logic [COUNT_BITS-1:0] jp_q, jp_d;
  logic [COUNT_BITS-1:0] midi_q, midi_d;

  // Clear wins; otherwise a new press bumps its bank's counter, any bank past joypad counting as midi.
  always_comb begin
    kb_d   = kb_q;
    jp_d   = jp_q;
    midi_d = midi_q;
    priority if (ctrl_i.clear) begin
      kb_d   = '0;
      jp_d   = '0;
      midi_d = '0;
    end else if (ctrl_i.incr) begin
      priority if (ctrl_i.bank == BANK_KEYBOARD) begin
        kb_d = kb_q + COUNT_BITS'(1);
      end else if (ctrl_i.bank == BANK_JOYPAD) begin
        jp_d = jp_q + COUNT_BITS'(1);
      end else begin
        midi_d = midi_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_q   <= '0;
      jp_q   <= '0;
      midi_q <= '0;
    end else begin
      kb_q   <= kb_d;
      jp_q   <= jp_d;
      midi_q <= midi_d;
    end
  end

  // Largest counter leads; ties go to keyboard, then joypad.
  always_comb begin
    priority if (kb_q >= jp_q && kb_q >= midi_q) begin
      leader_o = DEV_KEYBOARD;
    end else if (jp_q >= midi_q) begin
      leader_o = DEV_JOYPAD;
    end else begin
      leader_o = DEV_MIDI;
    end
  end

  assign keyboard_o = kb_q;
  assign joypad_o   = jp_q;
  assign midi_o     = midi_q;

endmodule
